FILE: sv/sotq_pkg.sv
`default_nettype none

package sotq_pkg;

    // Pool geometry
    localparam int unsigned SLOTS   = 32;
    localparam int unsigned ID_W    = $clog2(SLOTS);
    localparam int unsigned PTR_W   = $clog2(SLOTS + 1);
    localparam int unsigned MAX_RES = 32;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [PTR_W-1:0] NIL   = PTR_W'(SLOTS);
    localparam logic [31:0]      NEVER = 32'hffff_ffff;

    // Command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ALLOC   = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_BIND    = 3'd3;
    localparam logic [2:0] CMD_START   = 3'd4;
    localparam logic [2:0] CMD_CANCEL  = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_SWITCH  = 2'd2;

    // Slot status codes
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] id;
        logic            ok;
        logic [7:0]      fifo;
        logic [31:0]     data;
        logic            last;
    } res_t;

    typedef struct packed {
        logic            re;
        logic [ID_W-1:0] raddr;
        logic            we;
        logic [ID_W-1:0] waddr;
    } ram_ctl_t;

endpackage

`default_nettype wire

FILE: sv/sorted_oneshot_timer_queue_core.sv
`default_nettype none

// Channel  Dir  Beat contents (low bit first)
// s_*      in   tuser: command[2:0]; tdata: timer_id, delay, fifo_id, data_value
// m_*      out  tuser: result_kind[1:0]; tdata: out_timer_id, ok, out_fifo_id,
//               out_data; tlast: last
// cfg_*    in   task_timer_id, written when cfg_wr_en is high
//
// One command at a time. Bind, and release or cancel of an idle slot, go straight
// to the status beat. Allocate: one slot per cycle. Unlink and insert walk the
// linked list in the next-pointer memory, one entry at a time. Tick pops expired
// timers from the head, then flushes.
// Reset is asynchronous: list empty, all slots free, no memory clearing.
// A stalled m_tready holds the sequencer once the output register is full.

module sorted_oneshot_timer_queue_core
    import sotq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,   // task_timer_id
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,       // timer_id, delay, fifo_id, data_value, pad
    input  wire logic [2:0]  s_tuser,       // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,       // out_timer_id, ok, out_fifo_id, out_data, pad
    output logic      [1:0]  m_tuser,       // result_kind
    output logic             m_tlast
);

    ram_ctl_t         dl_ctl, nx_ctl, pl_ctl;
    logic [31:0]      dl_wdata, dl_rdata;
    logic [PTR_W-1:0] nx_wdata, nx_rdata;
    logic [39:0]      pl_wdata, pl_rdata;
    logic             res_valid, res_ready;
    res_t             res;
    logic             out_valid_reg;
    res_t             out_reg;

    sotq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_id       (s_tdata[4:0]),
        .in_delay    (s_tdata[36:5]),
        .in_fifo     (s_tdata[44:37]),
        .in_data     (s_tdata[76:45]),
        .dl_ctl      (dl_ctl),
        .dl_wdata    (dl_wdata),
        .dl_rdata    (dl_rdata),
        .nx_ctl      (nx_ctl),
        .nx_wdata    (nx_wdata),
        .nx_rdata    (nx_rdata),
        .pl_ctl      (pl_ctl),
        .pl_wdata    (pl_wdata),
        .pl_rdata    (pl_rdata),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    sotq_ram #(.W(32), .DEPTH(SLOTS)) u_dl_ram (
        .clk   (clk),
        .re    (dl_ctl.re),
        .raddr (dl_ctl.raddr),
        .rdata (dl_rdata),
        .we    (dl_ctl.we),
        .waddr (dl_ctl.waddr),
        .wdata (dl_wdata)
    );

    sotq_ram #(.W(PTR_W), .DEPTH(SLOTS)) u_nx_ram (
        .clk   (clk),
        .re    (nx_ctl.re),
        .raddr (nx_ctl.raddr),
        .rdata (nx_rdata),
        .we    (nx_ctl.we),
        .waddr (nx_ctl.waddr),
        .wdata (nx_wdata)
    );

    sotq_ram #(.W(40), .DEPTH(SLOTS)) u_pl_ram (
        .clk   (clk),
        .re    (pl_ctl.re),
        .raddr (pl_ctl.raddr),
        .rdata (pl_rdata),
        .we    (pl_ctl.we),
        .waddr (pl_ctl.waddr),
        .wdata (pl_wdata)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.data, out_reg.fifo, out_reg.ok, out_reg.id};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // Checks
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
        else $error("status beat not marked last");

    a_switch_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SWITCH) |-> m_tlast && m_tdata[5])
        else $error("task switch beat malformed");

    a_deliver_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DELIVER) |-> m_tdata[5])
        else $error("delivery beat without ok");

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != CMD_TICK) |=> !s_tready)
        else $error("command accepted without entering a work state");

endmodule

`default_nettype wire

FILE: sv/sotq_ram.sv
`default_nettype none

module sotq_ram #(
    parameter int unsigned W     = 32,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata
);

    logic [W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sotq_ctrl.sv
`default_nettype none

module sotq_ctrl
    import sotq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [5:0]       cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [2:0]       in_cmd,
    input  wire logic [ID_W-1:0]  in_id,
    input  wire logic [31:0]      in_delay,
    input  wire logic [7:0]       in_fifo,
    input  wire logic [31:0]      in_data,
    output ram_ctl_t              dl_ctl,
    output logic      [31:0]      dl_wdata,
    input  wire logic [31:0]      dl_rdata,
    output ram_ctl_t              nx_ctl,
    output logic      [PTR_W-1:0] nx_wdata,
    input  wire logic [PTR_W-1:0] nx_rdata,
    output ram_ctl_t              pl_ctl,
    output logic      [39:0]      pl_wdata,
    input  wire logic [39:0]      pl_rdata,
    output logic                  res_valid,
    output res_t                  res,
    input  wire logic             res_ready
);

    typedef enum logic [3:0] {
        S_IDLE, S_T_RD, S_T_CHK, S_T_FIN, S_A_SCAN, S_U_S, S_U_E, S_U_W,
        S_POST, S_I_GO, S_I_N, S_I_D, S_I_W1, S_I_W2, S_CMD_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [31:0]       count_reg, count_next;
    logic [31:0]       earliest_reg, earliest_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [5:0]        task_reg;
    logic [2:0]        cmd_reg, cmd_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [31:0]       dl_reg, dl_next;
    logic              ok_reg, ok_next;
    logic [ID_W-1:0]   oid_reg, oid_next;
    logic [PTR_W-1:0]  nxts_reg, nxts_next;
    logic [ID_W-1:0]   p_reg, p_next;
    logic [PTR_W-1:0]  q_reg, q_next;
    logic [ID_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              sw_reg, sw_next;
    logic              pend_v_reg, pend_v_next;
    res_t              pend_reg, pend_next;
    logic [1:0]        status_reg [SLOTS];

    logic              st_we;
    logic [ID_W-1:0]   st_idx;
    logic [1:0]        st_val;
    logic [31:0]       count_inc;
    logic              is_task;
    logic              stop;
    logic [ID_W-1:0]   head_id;

    assign count_inc = count_reg + 32'd1;
    assign head_id   = head_reg[ID_W-1:0];
    assign is_task   = (PTR_W'(task_reg) == head_reg);

    // Pop stops at a future deadline or at the result cap
    always_comb
    begin
        stop = (dl_rdata > count_reg);
        if (is_task)
        begin
            if (!sw_reg && (n_reg == CNT_W'(MAX_RES)))
            begin
                stop = 1'b1;
            end
        end
        else if ((n_reg + CNT_W'(sw_reg)) >= CNT_W'(MAX_RES))
        begin
            stop = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        earliest_next = earliest_reg;
        head_next     = head_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        dl_next       = dl_reg;
        ok_next       = ok_reg;
        oid_next      = oid_reg;
        nxts_next     = nxts_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        sw_next       = sw_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        st_we         = 1'b0;
        st_idx        = id_reg;
        st_val        = ST_ALLOC;
        dl_ctl        = '0;
        nx_ctl        = '0;
        pl_ctl        = '0;
        dl_wdata      = dl_reg;
        nx_wdata      = head_reg;
        pl_wdata      = {in_data, in_fifo};
        res_valid     = 1'b0;
        res           = '0;
        in_ready      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = in_cmd;
                    id_next  = in_id;
                    dl_next  = count_reg + in_delay;
                    ok_next  = 1'b0;
                    oid_next = '0;
                    case (in_cmd)
                        CMD_TICK:
                        begin
                            count_next = count_inc;
                            if (earliest_reg <= count_inc)
                            begin
                                n_next      = '0;
                                sw_next     = 1'b0;
                                pend_v_next = 1'b0;
                                state_next  = S_T_RD;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            cnt_next   = '0;
                            state_next = S_A_SCAN;
                        end
                        CMD_RELEASE:
                        begin
                            state_next = S_CMD_OUT;
                            if (status_reg[in_id] == ST_RUN)
                            begin
                                nx_ctl.re    = 1'b1;
                                nx_ctl.raddr = in_id;
                                state_next   = S_U_S;
                            end
                            else if (status_reg[in_id] != ST_FREE)
                            begin
                                st_we   = 1'b1;
                                st_idx  = in_id;
                                st_val  = ST_FREE;
                                ok_next = 1'b1;
                            end
                        end
                        CMD_BIND:
                        begin
                            pl_ctl.we    = 1'b1;
                            pl_ctl.waddr = in_id;
                            ok_next      = 1'b1;
                            state_next   = S_CMD_OUT;
                        end
                        CMD_START:
                        begin
                            state_next = S_CMD_OUT;
                            if (status_reg[in_id] != ST_FREE)
                            begin
                                dl_ctl.we    = 1'b1;
                                dl_ctl.waddr = in_id;
                                dl_wdata     = count_reg + in_delay;
                                state_next   = S_I_GO;
                                if (status_reg[in_id] == ST_RUN)
                                begin
                                    nx_ctl.re    = 1'b1;
                                    nx_ctl.raddr = in_id;
                                    state_next   = S_U_S;
                                end
                            end
                        end
                        CMD_CANCEL:
                        begin
                            state_next = S_CMD_OUT;
                            if (status_reg[in_id] == ST_RUN)
                            begin
                                nx_ctl.re    = 1'b1;
                                nx_ctl.raddr = in_id;
                                state_next   = S_U_S;
                            end
                        end
                        default:
                        begin
                            state_next = S_CMD_OUT;
                        end
                    endcase
                end
            end

            // Tick: fetch the head entry, or finish when the list is empty
            S_T_RD:
            begin
                if (head_reg >= NIL)
                begin
                    earliest_next = NEVER;
                    state_next    = S_T_FIN;
                end
                else
                begin
                    dl_ctl.re    = 1'b1;
                    dl_ctl.raddr = head_id;
                    nx_ctl.re    = 1'b1;
                    nx_ctl.raddr = head_id;
                    pl_ctl.re    = 1'b1;
                    pl_ctl.raddr = head_id;
                    state_next   = S_T_CHK;
                end
            end

            // Tick: stop, or pop the head and, unless it is the task timer, push out the previous delivery
            S_T_CHK:
            begin
                if (stop)
                begin
                    earliest_next = dl_rdata;
                    state_next    = S_T_FIN;
                end
                else if (is_task)
                begin
                    head_next  = nx_rdata;
                    st_we      = 1'b1;
                    st_idx     = head_id;
                    sw_next    = 1'b1;
                    state_next = S_T_RD;
                end
                else
                begin
                    res_valid = pend_v_reg;
                    res       = pend_reg;
                    if (!pend_v_reg || res_ready)
                    begin
                        head_next      = nx_rdata;
                        st_we          = 1'b1;
                        st_idx         = head_id;
                        pend_v_next    = 1'b1;
                        pend_next.kind = KIND_DELIVER;
                        pend_next.id   = head_id;
                        pend_next.ok   = 1'b1;
                        pend_next.fifo = pl_rdata[7:0];
                        pend_next.data = pl_rdata[39:8];
                        pend_next.last = 1'b0;
                        n_next         = n_reg + CNT_W'(1);
                        state_next     = S_T_RD;
                    end
                end
            end

            // Tick: flush the held delivery, then the task switch
            S_T_FIN:
            begin
                if (pend_v_reg)
                begin
                    res_valid = 1'b1;
                    res       = pend_reg;
                    res.last  = !sw_reg;
                    if (res_ready)
                    begin
                        pend_v_next = 1'b0;
                        if (!sw_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (sw_reg)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_SWITCH;
                    res.id    = task_reg[ID_W-1:0];
                    res.ok    = 1'b1;
                    res.last  = 1'b1;
                    if (res_ready)
                    begin
                        sw_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // Allocate: lowest free slot, one slot per cycle
            S_A_SCAN:
            begin
                if (status_reg[cnt_reg] == ST_FREE)
                begin
                    st_we      = 1'b1;
                    st_idx     = cnt_reg;
                    ok_next    = 1'b1;
                    oid_next   = cnt_reg;
                    state_next = S_CMD_OUT;
                end
                else if (cnt_reg == ID_W'(SLOTS - 1))
                begin
                    state_next = S_CMD_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + ID_W'(1);
                end
            end

            // Unlink: successor of the slot is known
            S_U_S:
            begin
                nxts_next = nx_rdata;
                if (head_reg == PTR_W'(id_reg))
                begin
                    head_next = nx_rdata;
                    if (nx_rdata >= NIL)
                    begin
                        earliest_next = NEVER;
                        state_next    = S_POST;
                    end
                    else
                    begin
                        dl_ctl.re    = 1'b1;
                        dl_ctl.raddr = nx_rdata[ID_W-1:0];
                        state_next   = S_U_E;
                    end
                end
                else
                begin
                    p_next       = head_id;
                    nx_ctl.re    = 1'b1;
                    nx_ctl.raddr = head_id;
                    state_next   = S_U_W;
                end
            end

            S_U_E:
            begin
                earliest_next = dl_rdata;
                state_next    = S_POST;
            end

            // Unlink: walk to the predecessor
            S_U_W:
            begin
                if (nx_rdata == PTR_W'(id_reg))
                begin
                    nx_ctl.we    = 1'b1;
                    nx_ctl.waddr = p_reg;
                    nx_wdata     = nxts_reg;
                    state_next   = S_POST;
                end
                else if (nx_rdata >= NIL)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    p_next       = nx_rdata[ID_W-1:0];
                    nx_ctl.re    = 1'b1;
                    nx_ctl.raddr = nx_rdata[ID_W-1:0];
                end
            end

            S_POST:
            begin
                ok_next    = 1'b1;
                state_next = S_CMD_OUT;
                case (cmd_reg)
                    CMD_RELEASE:
                    begin
                        st_we  = 1'b1;
                        st_val = ST_FREE;
                    end
                    CMD_CANCEL:
                    begin
                        st_we = 1'b1;
                    end
                    CMD_START:
                    begin
                        state_next = S_I_GO;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            // Insert: at the head when it is earliest, else walk
            S_I_GO:
            begin
                st_we   = 1'b1;
                st_val  = ST_RUN;
                ok_next = 1'b1;
                if ((head_reg >= NIL) || (dl_reg <= earliest_reg))
                begin
                    nx_ctl.we     = 1'b1;
                    nx_ctl.waddr  = id_reg;
                    nx_wdata      = head_reg;
                    head_next     = PTR_W'(id_reg);
                    earliest_next = dl_reg;
                    state_next    = S_CMD_OUT;
                end
                else
                begin
                    p_next       = head_id;
                    nx_ctl.re    = 1'b1;
                    nx_ctl.raddr = head_id;
                    state_next   = S_I_N;
                end
            end

            S_I_N:
            begin
                q_next = nx_rdata;
                if (nx_rdata >= NIL)
                begin
                    state_next = S_I_W1;
                end
                else
                begin
                    dl_ctl.re    = 1'b1;
                    dl_ctl.raddr = nx_rdata[ID_W-1:0];
                    state_next   = S_I_D;
                end
            end

            S_I_D:
            begin
                if (dl_reg <= dl_rdata)
                begin
                    state_next = S_I_W1;
                end
                else
                begin
                    p_next       = q_reg[ID_W-1:0];
                    nx_ctl.re    = 1'b1;
                    nx_ctl.raddr = q_reg[ID_W-1:0];
                    state_next   = S_I_N;
                end
            end

            S_I_W1:
            begin
                nx_ctl.we    = 1'b1;
                nx_ctl.waddr = id_reg;
                nx_wdata     = q_reg;
                state_next   = S_I_W2;
            end

            S_I_W2:
            begin
                nx_ctl.we    = 1'b1;
                nx_ctl.waddr = p_reg;
                nx_wdata     = PTR_W'(id_reg);
                state_next   = S_CMD_OUT;
            end

            S_CMD_OUT:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_STATUS;
                res.id    = oid_reg;
                res.ok    = ok_reg;
                res.last  = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            earliest_reg <= NEVER;
            head_reg     <= NIL;
            task_reg     <= 6'(SLOTS);
            sw_reg       <= 1'b0;
            pend_v_reg   <= 1'b0;
            n_reg        <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
            end
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            earliest_reg <= earliest_next;
            head_reg     <= head_next;
            sw_reg       <= sw_next;
            pend_v_reg   <= pend_v_next;
            n_reg        <= n_next;
            if (cfg_wr_en)
            begin
                task_reg <= cfg_wr_data;
            end
            if (st_we)
            begin
                status_reg[st_idx] <= st_val;
            end
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        id_reg   <= id_next;
        dl_reg   <= dl_next;
        ok_reg   <= ok_next;
        oid_reg  <= oid_next;
        nxts_reg <= nxts_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire
